/* rtl/gpwm_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// gpwm_pkg
// Shared types, register map, status codes and scaling constants of the
// gated pulse width meter.
// ============================================================================
package gpwm_pkg;

   localparam int COUNTER_WIDTH_DEFAULT = 16;
   localparam int WRAP_WIDTH            = 16;
   localparam int ADDR_WIDTH            = 5;

   localparam logic [2:0] REG_ACTIVE_LOW    = 3'd0;
   localparam logic [2:0] REG_FILTER_ENABLE = 3'd1;
   localparam logic [2:0] REG_WINDOW_LOW    = 3'd2;
   localparam logic [2:0] REG_WINDOW_HIGH   = 3'd3;
   localparam logic [2:0] REG_TIMEOUT       = 3'd4;

   localparam logic [15:0] WINDOW_LOW_RESET  = 16'd574;
   localparam logic [15:0] WINDOW_HIGH_RESET = 16'd579;
   localparam logic [31:0] TIMEOUT_RESET     = 32'd96000000;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ZERO    = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   // ns = floor(ticks * 125 / 12); saturates from this tick count on
   localparam logic [31:0] NS_SAT_TICKS   = 32'd412316861;
   localparam logic [31:0] NS_PER_GROUP   = 32'd125;
   localparam logic [29:0] TICKS_PER_GROUP = 30'd12;
   localparam int          RECIP_SHIFT    = 29;
   localparam logic [27:0] RECIP_THIRD    = 28'd178956971;

   typedef struct packed {
      logic pulse_level;
      logic arm;
   } in_type;

   typedef struct packed {
      logic [31:0] width_ticks;
      logic [31:0] width_ns;
      logic [1:0]  status;
   } out_type;

   typedef struct packed {
      logic        active_low;
      logic        glitch_filter_enable;
      logic [15:0] glitch_window_low;
      logic [15:0] glitch_window_high;
      logic [31:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [31:0] width_ticks;
      logic [1:0]  status;
   } stage_type;

   function automatic logic [6:0] ns_frac(input logic [3:0] rem);
      logic [6:0] val;
      case (rem)
         4'd0:    val = 7'd0;
         4'd1:    val = 7'd10;
         4'd2:    val = 7'd20;
         4'd3:    val = 7'd31;
         4'd4:    val = 7'd41;
         4'd5:    val = 7'd52;
         4'd6:    val = 7'd62;
         4'd7:    val = 7'd72;
         4'd8:    val = 7'd83;
         4'd9:    val = 7'd93;
         4'd10:   val = 7'd104;
         4'd11:   val = 7'd114;
         default: val = 7'd0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/gpwm_csr.sv */
`timescale 1ns / 1ps
// ============================================================================
// gpwm_csr
// APB-style configuration registers with read back.
// ============================================================================
module gpwm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gpwm_pkg::ADDR_WIDTH-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output gpwm_pkg::cfg_type                   cfg
);

   gpwm_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low           <= 1'b0;
         cfg_ff.glitch_filter_enable <= 1'b0;
         cfg_ff.glitch_window_low    <= gpwm_pkg::WINDOW_LOW_RESET;
         cfg_ff.glitch_window_high   <= gpwm_pkg::WINDOW_HIGH_RESET;
         cfg_ff.timeout_ticks        <= gpwm_pkg::TIMEOUT_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            gpwm_pkg::REG_ACTIVE_LOW:    cfg_ff.active_low           <= pwdata[0];
            gpwm_pkg::REG_FILTER_ENABLE: cfg_ff.glitch_filter_enable <= pwdata[0];
            gpwm_pkg::REG_WINDOW_LOW:    cfg_ff.glitch_window_low    <= pwdata[15:0];
            gpwm_pkg::REG_WINDOW_HIGH:   cfg_ff.glitch_window_high   <= pwdata[15:0];
            gpwm_pkg::REG_TIMEOUT:       cfg_ff.timeout_ticks        <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         gpwm_pkg::REG_ACTIVE_LOW:    prdata = {31'd0, cfg_ff.active_low};
         gpwm_pkg::REG_FILTER_ENABLE: prdata = {31'd0, cfg_ff.glitch_filter_enable};
         gpwm_pkg::REG_WINDOW_LOW:    prdata = {16'd0, cfg_ff.glitch_window_low};
         gpwm_pkg::REG_WINDOW_HIGH:   prdata = {16'd0, cfg_ff.glitch_window_high};
         gpwm_pkg::REG_TIMEOUT:       prdata = cfg_ff.timeout_ticks;
         default:                     prdata = 32'd0;
      endcase
   end

endmodule

/* rtl/gpwm_gate.sv */
`timescale 1ns / 1ps
// ============================================================================
// gpwm_gate
// Gate counter, arm and timeout state; forms the tick total of each result
// beat and holds it in the first pipeline register.
// ============================================================================
module gpwm_gate #(
   parameter int COUNTER_WIDTH = gpwm_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gpwm_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gpwm_pkg::in_type     req_data,
   output logic                 s1_valid,
   input  logic                 s1_ready,
   output gpwm_pkg::stage_type  s1_data
);

   localparam int WW = COUNTER_WIDTH + gpwm_pkg::WRAP_WIDTH;

   logic [COUNTER_WIDTH-1:0]        cnt_ff, cnt_in, cnt_base, raw;
   logic [gpwm_pkg::WRAP_WIDTH-1:0] wraps_ff, wraps_in, wraps_base, wraps_raw;
   logic [31:0]                     wait_ff, wait_in;
   logic                            armed_ff, armed_in;
   logic                            active_ff, active_in;
   logic                            s1_valid_ff, s1_valid_in;
   gpwm_pkg::stage_type             s1_data_ff, s1_data_in;
   logic                            accept, level, in_window, edge_fire;
   logic [WW-1:0]                   total_wide;
   logic [31:0]                     total;

   assign req_ready = !s1_valid_ff || s1_ready;
   assign accept    = req_valid && req_ready;
   assign s1_valid  = s1_valid_ff;
   assign s1_data   = s1_data_ff;

   always_comb begin
      level      = req_data.pulse_level ^ cfg.active_low;
      cnt_in     = cnt_ff;
      wraps_in   = wraps_ff;
      wait_in    = wait_ff;
      armed_in   = armed_ff;
      active_in  = active_ff;
      cnt_base   = active_ff ? cnt_ff : '0;
      wraps_base = active_ff ? wraps_ff : '0;
      in_window  = cfg.glitch_filter_enable
                   && (cnt_ff > COUNTER_WIDTH'(cfg.glitch_window_low))
                   && (cnt_ff < COUNTER_WIDTH'(cfg.glitch_window_high));
      raw        = in_window ? '0 : cnt_ff;
      wraps_raw  = in_window ? '0 : wraps_ff;
      total_wide = {wraps_raw, raw};
      total      = ((total_wide >> 32) != '0) ? 32'hFFFF_FFFF : total_wide[31:0];
      edge_fire  = 1'b0;
      s1_valid_in = 1'b0;
      s1_data_in.width_ticks = total;
      s1_data_in.status = (total == 32'd0) ? gpwm_pkg::STATUS_ZERO : gpwm_pkg::STATUS_OK;
      if (req_data.arm) begin
         cnt_in    = '0;
         wraps_in  = '0;
         wait_in   = '0;
         active_in = 1'b0;
         armed_in  = 1'b1;
      end else begin
         if (level) begin
            active_in = 1'b1;
            if (&cnt_base) begin
               cnt_in   = '0;
               wraps_in = (&wraps_base) ? wraps_base : wraps_base + 1'b1;
            end else begin
               cnt_in   = cnt_base + 1'b1;
               wraps_in = wraps_base;
            end
         end else if (active_ff) begin
            active_in = 1'b0;
            if (armed_ff) begin
               edge_fire   = 1'b1;
               armed_in    = 1'b0;
               s1_valid_in = 1'b1;
            end
         end
         if (armed_ff && !edge_fire) begin
            wait_in = (&wait_ff) ? wait_ff : wait_ff + 1'b1;
            if (wait_in >= cfg.timeout_ticks) begin
               armed_in    = 1'b0;
               s1_valid_in = 1'b1;
               s1_data_in.width_ticks = 32'd0;
               s1_data_in.status      = gpwm_pkg::STATUS_TIMEOUT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         wraps_ff    <= '0;
         wait_ff     <= '0;
         armed_ff    <= 1'b0;
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            cnt_ff    <= cnt_in;
            wraps_ff  <= wraps_in;
            wait_ff   <= wait_in;
            armed_ff  <= armed_in;
            active_ff <= active_in;
         end
         if (req_ready) begin
            s1_valid_ff <= accept && s1_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_data_ff <= s1_data_in;
      end
   end

endmodule

/* rtl/gpwm_ns_scale.sv */
`timescale 1ns / 1ps
// ============================================================================
// gpwm_ns_scale
// Two-stage tick to nanosecond scaling, floor(ticks * 125 / 12) with
// saturation, ending in the result register.
// ============================================================================
module gpwm_ns_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 s1_valid,
   output logic                 s1_ready,
   input  gpwm_pkg::stage_type  s1_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gpwm_pkg::out_type    rsp_data
);

   logic                 s2_valid_ff, s2_ready, rsp_valid_ff, rsp_load;
   logic [54:0]          prod;
   logic [25:0]          quot_ff;
   logic [31:0]          ticks_ff;
   logic [1:0]           status_ff;
   logic                 sat_ff;
   logic [29:0]          quot12;
   logic [3:0]           rem;
   logic [31:0]          ns_val;
   gpwm_pkg::out_type    rsp_data_ff, rsp_data_in;

   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = rsp_load;
   assign s1_ready  = !s2_valid_ff || s2_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // quotient of ticks / 12 via reciprocal of 3 on ticks / 4
   assign prod = 55'(s1_data.width_ticks[28:2]) * 55'(gpwm_pkg::RECIP_THIRD);

   always_comb begin
      quot12 = 30'(quot_ff) * gpwm_pkg::TICKS_PER_GROUP;
      rem    = ticks_ff[3:0] - quot12[3:0];
      ns_val = 32'(quot_ff) * gpwm_pkg::NS_PER_GROUP + 32'(gpwm_pkg::ns_frac(rem));
      rsp_data_in.width_ticks = ticks_ff;
      rsp_data_in.width_ns    = sat_ff ? 32'hFFFF_FFFF : ns_val;
      rsp_data_in.status      = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s2_valid_ff <= s1_valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         quot_ff   <= prod[54:gpwm_pkg::RECIP_SHIFT];
         ticks_ff  <= s1_data.width_ticks;
         status_ff <= s1_data.status;
         sat_ff    <= s1_data.width_ticks >= gpwm_pkg::NS_SAT_TICKS;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* rtl/gated_pulse_width_meter_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// gated_pulse_width_meter_core
// Gated pulse width capture timer: one input beat per timer tick, one result
// beat per measured pulse or timeout.
// ============================================================================
//  channel   direction  handshake                 payload
//  req       in         req_valid / req_ready     gpwm_pkg::in_type
//  rsp       out        rsp_valid / rsp_ready     gpwm_pkg::out_type
//  csr       in         psel penable pwrite pready APB-style, 32-bit data
//
//  One input beat per clock while req_ready is high. A result beat passes
//  through the gate register, reciprocal multiply register and result
//  register. Synchronous reset clears counts, arm state and all valid bits.
//  Under rsp stall the pipeline holds up to three results and req_ready
//  drops only when all three stages are full.
// ============================================================================
module gated_pulse_width_meter_core #(
   parameter int COUNTER_WIDTH = gpwm_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  gpwm_pkg::in_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output gpwm_pkg::out_type                rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gpwm_pkg::ADDR_WIDTH-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   gpwm_pkg::cfg_type   cfg;
   gpwm_pkg::stage_type s1_data;
   logic                s1_valid, s1_ready;

   gpwm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gpwm_gate #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_gate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .s1_valid  (s1_valid),
      .s1_ready  (s1_ready),
      .s1_data   (s1_data)
   );

   gpwm_ns_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_ready  (s1_ready),
      .s1_data   (s1_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/gpwm_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// gpwm_checker
// Port-level checks of the pulse width meter, bound to the top level.
// ============================================================================
module gpwm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input gpwm_pkg::out_type  rsp_data
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_req_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without result back pressure");

   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == gpwm_pkg::STATUS_TIMEOUT
      |-> rsp_data.width_ticks == 32'd0 && rsp_data.width_ns == 32'd0)
      else $error("timeout beat carries a width");

   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == gpwm_pkg::STATUS_OK
      |-> rsp_data.width_ticks != 32'd0 && rsp_data.width_ns >= rsp_data.width_ticks)
      else $error("ok beat with inconsistent width");

endmodule

bind gated_pulse_width_meter_core gpwm_checker u_gpwm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* bench/gated_pulse_width_meter_core_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// gated_pulse_width_meter_core_test
// Self-checking bench for the gated pulse width meter. A queue of tick beats
// feeds a valid/ready driver, a model of the meter predicts every result at
// the input handshake, and a monitor checks each result beat against the
// oldest prediction. Registers are written over the APB-style port between
// phases and read back. Phases cover polarity, filter windows, timeouts,
// random traffic, a long result stall and random idling.
// ============================================================================
module gated_pulse_width_meter_core_test;

   localparam int          CW        = gpwm_pkg::COUNTER_WIDTH_DEFAULT;
   localparam logic [31:0] COUNT_MAX = 32'((64'd1 << CW) - 1);
   localparam int          HOLD_LEN  = 400;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   gpwm_pkg::in_type                req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   gpwm_pkg::out_type               rsp_data;
   logic                            psel      = 1'b0;
   logic                            penable   = 1'b0;
   logic                            pwrite    = 1'b0;
   logic [gpwm_pkg::ADDR_WIDTH-1:0] paddr     = '0;
   logic [31:0]                     pwdata    = '0;
   logic [31:0]                     prdata;
   logic                            pready;

   gated_pulse_width_meter_core #(.COUNTER_WIDTH(CW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   gpwm_pkg::in_type  tick_queue[$];
   gpwm_pkg::out_type expected_widths[$];
   int      ticks_queued  = 0;
   int      mismatches    = 0;
   int      req_idle_pct  = 32;
   int      rsp_stall_pct = 32;
   int      hold_requests = 0;
   int      hold_seen     = 0;
   int      hold_left     = 0;
   logic    req_taken     = 1'b0;

   gpwm_pkg::cfg_type meter_cfg;
   logic [31:0] tick_count;
   logic [15:0] wrap_count;
   logic [31:0] wait_count;
   logic        armed;
   logic        in_pulse;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic measure_tick(input gpwm_pkg::in_type beat);
      logic              level;
      logic [63:0]       raw;
      logic [63:0]       wraps;
      logic [63:0]       total;
      logic [63:0]       ns;
      gpwm_pkg::out_type res;
      level = beat.pulse_level ^ meter_cfg.active_low;
      if (beat.arm) begin
         tick_count = '0;
         wrap_count = '0;
         wait_count = '0;
         in_pulse   = 1'b0;
         armed      = 1'b1;
         return;
      end
      if (level) begin
         if (!in_pulse) begin
            tick_count = '0;
            wrap_count = '0;
            in_pulse   = 1'b1;
         end
         if (tick_count >= COUNT_MAX) begin
            tick_count = '0;
            if (wrap_count != 16'hFFFF) wrap_count = wrap_count + 1'b1;
         end else begin
            tick_count = tick_count + 1'b1;
         end
      end else if (in_pulse) begin
         in_pulse = 1'b0;
         raw      = 64'(tick_count);
         wraps    = 64'(wrap_count);
         if (meter_cfg.glitch_filter_enable && raw > meter_cfg.glitch_window_low &&
             raw < meter_cfg.glitch_window_high) begin
            raw   = '0;
            wraps = '0;
         end
         if (armed) begin
            total = raw + (wraps << CW);
            if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
            ns = (total * 64'd125) / 64'd12;
            if (ns > 64'hFFFF_FFFF) ns = 64'hFFFF_FFFF;
            res.width_ticks = total[31:0];
            res.width_ns    = ns[31:0];
            res.status      = (total == 0) ? gpwm_pkg::STATUS_ZERO : gpwm_pkg::STATUS_OK;
            expected_widths.push_back(res);
            armed = 1'b0;
            return;
         end
      end
      if (armed) begin
         if (wait_count != 32'hFFFF_FFFF) wait_count = wait_count + 1'b1;
         if (wait_count >= meter_cfg.timeout_ticks) begin
            res.width_ticks = '0;
            res.width_ns    = '0;
            res.status      = gpwm_pkg::STATUS_TIMEOUT;
            expected_widths.push_back(res);
            armed = 1'b0;
         end
      end
   endtask

   // drive request beats at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (tick_queue.size() > 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            req_data  <= tick_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result backpressure: random stalls plus long holds on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_LEN;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      gpwm_pkg::out_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) measure_tick(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_widths.size() == 0) begin
               $error("unexpected result beat: width_ticks %0d width_ns %0d status %0d",
                      rsp_data.width_ticks, rsp_data.width_ns, rsp_data.status);
               mismatches++;
            end else begin
               want = expected_widths.pop_front();
               if (rsp_data.width_ticks !== want.width_ticks) begin
                  $error("width_ticks expected %0d actual %0d",
                         want.width_ticks, rsp_data.width_ticks);
                  mismatches++;
               end
               if (rsp_data.width_ns !== want.width_ns) begin
                  $error("width_ns expected %0d actual %0d", want.width_ns, rsp_data.width_ns);
                  mismatches++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic tick(input bit level, input bit strobe);
      gpwm_pkg::in_type beat;
      beat.pulse_level = level ^ meter_cfg.active_low;
      beat.arm         = strobe;
      tick_queue.push_back(beat);
      ticks_queued++;
   endtask

   task automatic pulse_run(input bit level, input int count);
      repeat (count) tick(level, 1'b0);
   endtask

   task automatic settle();
      while (tick_queue.size() != 0 || req_valid || expected_widths.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      logic [31:0] stored;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         gpwm_pkg::REG_ACTIVE_LOW: begin
            meter_cfg.active_low = value[0];
            stored = {31'd0, value[0]};
         end
         gpwm_pkg::REG_FILTER_ENABLE: begin
            meter_cfg.glitch_filter_enable = value[0];
            stored = {31'd0, value[0]};
         end
         gpwm_pkg::REG_WINDOW_LOW: begin
            meter_cfg.glitch_window_low = value[15:0];
            stored = {16'd0, value[15:0]};
         end
         gpwm_pkg::REG_WINDOW_HIGH: begin
            meter_cfg.glitch_window_high = value[15:0];
            stored = {16'd0, value[15:0]};
         end
         default: begin
            meter_cfg.timeout_ticks = value;
            stored = value;
         end
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== stored) begin
         $error("csr %0d readback expected %0d actual %0d", index, stored, prdata);
         mismatches++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(input bit pol, input bit filt, input logic [15:0] lo,
                             input logic [15:0] hi, input logic [31:0] limit);
      settle();
      csr_write(gpwm_pkg::REG_ACTIVE_LOW, {31'd0, pol});
      csr_write(gpwm_pkg::REG_FILTER_ENABLE, {31'd0, filt});
      csr_write(gpwm_pkg::REG_WINDOW_LOW, {16'd0, lo});
      csr_write(gpwm_pkg::REG_WINDOW_HIGH, {16'd0, hi});
      csr_write(gpwm_pkg::REG_TIMEOUT, limit);
   endtask

   task automatic random_traffic(input int target);
      int start;
      int pick;
      int width;
      int cap;
      start = ticks_queued;
      while (ticks_queued - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            repeat ($urandom_range(0, 2)) tick(1'b0, 1'b0);
            tick(1'($urandom_range(0, 1)), 1'b1);
            repeat ($urandom_range(0, 3)) tick(1'b0, 1'b0);
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               width = $urandom_range(1, 12);
            end else if (pick < 8) begin
               width = (pick == 6) ? int'(meter_cfg.glitch_window_low)
                                   : int'(meter_cfg.glitch_window_high);
               width = width + $urandom_range(0, 2) - 1;
               if (width < 1 || width > 700) width = $urandom_range(1, 12);
            end else begin
               cap   = (meter_cfg.timeout_ticks > 77) ? 80 : int'(meter_cfg.timeout_ticks) + 3;
               width = $urandom_range(1, cap);
            end
            pulse_run(1'b1, width);
            tick(1'b0, 1'b0);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 6))
               tick(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
         end else if ($urandom_range(0, 1) == 0) begin
            pulse_run(1'b1, $urandom_range(1, 5));
            tick(1'b0, 1'b0);
         end else begin
            tick(1'b0, 1'b1);
            pulse_run(1'b1, $urandom_range(1, 4));
            tick(1'b1, 1'b1);
            pulse_run(1'b1, $urandom_range(0, 3));
            tick(1'b0, 1'b0);
         end
      end
   endtask

   initial begin
      meter_cfg.active_low           = 1'b0;
      meter_cfg.glitch_filter_enable = 1'b0;
      meter_cfg.glitch_window_low    = gpwm_pkg::WINDOW_LOW_RESET;
      meter_cfg.glitch_window_high   = gpwm_pkg::WINDOW_HIGH_RESET;
      meter_cfg.timeout_ticks        = gpwm_pkg::TIMEOUT_RESET;
      tick_count = '0;
      wrap_count = '0;
      wait_count = '0;
      armed      = 1'b0;
      in_pulse   = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: plain pulse, unarmed pulse, arm with pin active, re-arm
      tick(1'b0, 1'b0);
      tick(1'b0, 1'b1);
      pulse_run(1'b1, 3);
      tick(1'b0, 1'b0);
      pulse_run(1'b1, 2);
      tick(1'b0, 1'b0);
      tick(1'b1, 1'b1);
      pulse_run(1'b1, 2);
      tick(1'b0, 1'b0);
      tick(1'b0, 1'b1);
      tick(1'b1, 1'b1);
      pulse_run(1'b1, 1);
      tick(1'b0, 1'b0);

      // inverted pin, narrow filter: timeout, edge beats timeout, filtered width
      set_config(1'b1, 1'b1, 16'd0, 16'd2, 32'd3);
      tick(1'b0, 1'b1);
      pulse_run(1'b0, 3);
      tick(1'b0, 1'b1);
      pulse_run(1'b1, 2);
      tick(1'b0, 1'b0);
      tick(1'b0, 1'b1);
      pulse_run(1'b1, 1);
      tick(1'b0, 1'b0);

      // zero timeout expires on the first tick after arming
      set_config(1'b1, 1'b1, 16'd0, 16'd2, 32'd0);
      tick(1'b0, 1'b1);
      tick(1'b0, 1'b0);

      set_config(1'b0, 1'b1, 16'd3, 16'd9, 32'd40);
      random_traffic(200);

      // default glitch window drops a width just inside it
      set_config(1'b1, 1'b1, gpwm_pkg::WINDOW_LOW_RESET, gpwm_pkg::WINDOW_HIGH_RESET,
                 32'hFFFF_FFFF);
      tick(1'b0, 1'b1);
      pulse_run(1'b1, 575);
      tick(1'b0, 1'b0);

      set_config(1'b0, 1'b1, 16'd0, 16'd65535, 32'd1);
      random_traffic(150);

      // no idling on either side
      set_config(1'b1, 1'b0, 16'd65535, 16'd0, 32'd40);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      random_traffic(250);

      // hold results off while the sender keeps going
      set_config(1'b0, 1'b0, 16'd3, 16'd9, 32'd20);
      rsp_stall_pct = 32;
      hold_requests++;
      repeat (100) begin
         tick(1'b0, 1'b1);
         tick(1'b1, 1'b0);
         tick(1'b0, 1'b0);
      end
      random_traffic(50);

      req_idle_pct = 32;
      repeat (2) begin
         set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 40)), 16'($urandom_range(0, 80)),
                    32'($urandom_range(1, 60)));
         random_traffic(200);
      end

      settle();
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #10000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
rtl/gpwm_pkg.sv
rtl/gpwm_csr.sv
rtl/gpwm_gate.sv
rtl/gpwm_ns_scale.sv
rtl/gated_pulse_width_meter_core.sv
rtl/gpwm_checker.sv
bench/gated_pulse_width_meter_core_test.sv
